>>> sv/mcg_pkg.sv
`timescale 1ns / 1ps
// Types, codes and constants shared by the beat clock generator modules.
// No dependencies.
package mcg_pkg;

   localparam logic CMD_TICK    = 1'b0;
   localparam logic CMD_CONTROL = 1'b1;

   localparam logic MSG_REALTIME = 1'b0;
   localparam logic MSG_CONTROL  = 1'b1;

   localparam logic [7:0] ST_CLOCK = 8'hF8;
   localparam logic [7:0] ST_START = 8'hFA;
   localparam logic [7:0] ST_STOP  = 8'hFC;
   localparam logic [3:0] CC_STATUS_HI = 4'hB;

   typedef enum logic [2:0] {
      CSR_INITIAL_TEMPO        = 3'd0,
      CSR_PHASE_LIMIT          = 3'd1,
      CSR_CONTROL_CHANNEL      = 3'd2,
      CSR_STEER_CONTROLLER     = 3'd3,
      CSR_TRANSPORT_CONTROLLER = 3'd4,
      CSR_BROADCAST_CONTROLLER = 3'd5
   } csr_index_type;

   localparam logic [16:0] RESET_TEMPO      = 17'd31744;
   localparam logic [31:0] RESET_LIMIT      = 32'd640000000;
   localparam logic [3:0]  RESET_CHANNEL    = 4'd15;
   localparam logic [6:0]  RESET_STEER      = 7'd118;
   localparam logic [6:0]  RESET_TRANSPORT  = 7'd117;
   localparam logic [6:0]  RESET_BROADCAST  = 7'd119;

   localparam int TEMPO_MIN_Q8  = 10240;
   localparam int TEMPO_SPAN_Q8 = 92160;
   localparam int STEER_DIV     = 127;
   localparam int STEER_ROUND   = 63;
   localparam logic [17:0] TEMPO_HYST_Q8 = 18'd64;

   // tempo broadcast: ((t - min) * 127 + span / 2) / span, span = 1024 * 90
   localparam logic [23:0] BCAST_ROUND      = 24'd46080;
   localparam int          BCAST_SHIFT      = 10;
   localparam logic [13:0] BCAST_RECIP      = 14'd11651;
   localparam int          BCAST_RECIP_SHIFT = 20;
   localparam logic [7:0]  BCAST_MAX        = 8'd127;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef logic [16:0] steer_table_type [128];

   function automatic steer_table_type build_steer_table();
      steer_table_type t;
      for (int i = 0; i < 128; i++) begin
         t[i] = 17'(TEMPO_MIN_Q8 + (i * TEMPO_SPAN_Q8 + STEER_ROUND) / STEER_DIV);
      end
      return t;
   endfunction

   localparam steer_table_type STEER_TABLE = build_steer_table();

   typedef struct packed {
      logic [31:0] limit;
      logic [3:0]  channel;
      logic [6:0]  steer;
      logic [6:0]  transport;
      logic [6:0]  broadcast;
   } cfg_type;

   typedef struct packed {
      logic        xport_vld;
      logic        xport_start;
      logic        clock_vld;
      logic        bcast_vld;
      logic [13:0] bcast_y;
   } job_type;

endpackage

>>> sv/mcg_queue.sv
`timescale 1ns / 1ps
// Short job queue between the front and the back of the beat clock generator.
// Depends on mcg_pkg.
module mcg_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mcg_pkg::job_type push_job,
   input  logic             pop,
   output mcg_pkg::job_type head_job,
   output logic             nonempty,
   output logic             full
);

   localparam int CW = $clog2(mcg_pkg::QUEUE_DEPTH + 1);

   mcg_pkg::job_type                   slot_ff [mcg_pkg::QUEUE_DEPTH];
   logic [mcg_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [mcg_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]                      count_ff, count_in;

   assign nonempty = count_ff != '0;
   assign full     = count_ff == CW'(mcg_pkg::QUEUE_DEPTH);
   assign head_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(mcg_pkg::QUEUE_DEPTH))
      else $error("job queue count above depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> nonempty)
      else $error("job queue popped while empty");

endmodule

>>> sv/mcg_front.sv
`timescale 1ns / 1ps
// Front of the beat clock generator: takes ticks and controller words, keeps
// tempo, phase, transport and beat state, and queues the messages due. Depends on mcg_pkg.
module mcg_front #(
   parameter int PULSES_PER_BEAT = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_cmd,
   input  logic [3:0]       req_in_channel,
   input  logic [6:0]       req_in_controller,
   input  logic [6:0]       req_in_value,
   input  mcg_pkg::cfg_type cfg,
   input  logic             tempo_load,
   input  logic [16:0]      tempo_load_value,
   input  logic             queue_full,
   output logic             push,
   output mcg_pkg::job_type push_job
);

   localparam int BW = (PULSES_PER_BEAT > 1) ? $clog2(PULSES_PER_BEAT) : 1;

   logic [16:0]   tempo_ff, tempo_in;
   logic [31:0]   phase_ff, phase_in;
   logic          playing_ff, playing_in;
   logic          sent_known_ff, sent_known_in;
   logic          sent_play_ff, sent_play_in;
   logic [BW-1:0] beat_ff, beat_in;

   logic          accept;
   logic [32:0]   sum;
   logic [32:0]   wrapped;
   logic          wrap;
   logic          over;
   logic [16:0]   steer_tempo;
   logic [17:0]   steer_diff;
   logic          steer_apply;
   logic          xport_need;
   logic          beat_last;
   logic [16:0]   bdelta;
   logic [23:0]   bsum;
   logic [13:0]   bcast_y;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   assign sum     = {1'b0, phase_ff} + 33'(tempo_ff);
   assign wrap    = sum >= 33'(cfg.limit);
   assign over    = sum >= {cfg.limit, 1'b0};
   assign wrapped = sum - 33'(cfg.limit);

   assign steer_tempo = mcg_pkg::STEER_TABLE[req_in_value];
   assign steer_diff  = {1'b0, steer_tempo} - {1'b0, tempo_ff};
   assign steer_apply = (!steer_diff[17] && steer_diff > mcg_pkg::TEMPO_HYST_Q8) ||
                        (steer_diff[17] && (18'd0 - steer_diff) > mcg_pkg::TEMPO_HYST_Q8);

   assign xport_need = !sent_known_ff || (sent_play_ff != playing_ff);
   assign beat_last  = beat_ff == BW'(PULSES_PER_BEAT - 1);

   assign bdelta  = tempo_ff - 17'(mcg_pkg::TEMPO_MIN_Q8);
   assign bsum    = {bdelta, 7'b0} - 24'(bdelta) + mcg_pkg::BCAST_ROUND;
   assign bcast_y = (tempo_ff > 17'(mcg_pkg::TEMPO_MIN_Q8)) ?
                    bsum[mcg_pkg::BCAST_SHIFT +: 14] : 14'd0;

   always_comb begin
      tempo_in      = tempo_ff;
      phase_in      = phase_ff;
      playing_in    = playing_ff;
      sent_known_in = sent_known_ff;
      sent_play_in  = sent_play_ff;
      beat_in       = beat_ff;
      push          = 1'b0;
      push_job      = '0;
      if (accept) begin
         if (req_cmd == mcg_pkg::CMD_CONTROL) begin
            if (req_in_channel == cfg.channel) begin
               if (req_in_controller == cfg.steer) begin
                  if (steer_apply) begin
                     tempo_in = steer_tempo;
                  end
               end else if (req_in_controller == cfg.transport) begin
                  playing_in = req_in_value[6];
               end
            end
         end else if (!wrap) begin
            phase_in = sum[31:0];
         end else begin
            phase_in = over ? (cfg.limit - 32'd1) : wrapped[31:0];
            push_job.xport_vld   = xport_need;
            push_job.xport_start = playing_ff;
            push_job.clock_vld   = playing_ff;
            push_job.bcast_vld   = playing_ff && beat_last;
            push_job.bcast_y     = bcast_y;
            push = xport_need || playing_ff;
            if (xport_need) begin
               sent_known_in = 1'b1;
               sent_play_in  = playing_ff;
            end
            if (playing_ff) begin
               beat_in = beat_last ? '0 : beat_ff + 1'b1;
            end
         end
      end
      if (tempo_load) begin
         tempo_in = tempo_load_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tempo_ff      <= mcg_pkg::RESET_TEMPO;
         phase_ff      <= '0;
         playing_ff    <= 1'b1;
         sent_known_ff <= 1'b0;
         sent_play_ff  <= 1'b0;
         beat_ff       <= '0;
      end else begin
         tempo_ff      <= tempo_in;
         phase_ff      <= phase_in;
         playing_ff    <= playing_in;
         sent_known_ff <= sent_known_in;
         sent_play_ff  <= sent_play_in;
         beat_ff       <= beat_in;
      end
   end

   a_push_not_empty: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_job.xport_vld || push_job.clock_vld))
      else $error("empty job queued");

endmodule

>>> sv/mcg_back.sv
`timescale 1ns / 1ps
// Back of the beat clock generator: turns queued jobs into result words, one
// per cycle while unstalled, through an output register. Depends on mcg_pkg.
module mcg_back (
   input  logic             clock,
   input  logic             reset,
   input  mcg_pkg::cfg_type cfg,
   input  mcg_pkg::job_type head_job,
   input  logic             queue_nonempty,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_msg_kind,
   output logic [7:0]       rsp_status_byte,
   output logic [3:0]       rsp_out_channel,
   output logic [6:0]       rsp_out_controller,
   output logic [6:0]       rsp_out_value,
   output logic             rsp_last
);

   logic [2:0]  done_ff, done_in;
   logic        valid_ff, valid_in;
   logic        kind_ff, kind_in;
   logic [7:0]  status_ff, status_in;
   logic [3:0]  channel_ff, channel_in;
   logic [6:0]  ctrl_ff, ctrl_in;
   logic [6:0]  value_ff, value_in;
   logic        last_ff, last_in;

   logic        load;
   logic        rem_x, rem_c, rem_b;
   logic        sel_x, sel_c;
   logic        is_last;
   logic [27:0] bprod;
   logic [7:0]  bquot;
   logic [6:0]  bvalue;

   assign rem_x = head_job.xport_vld && !done_ff[0];
   assign rem_c = head_job.clock_vld && !done_ff[1];
   assign rem_b = head_job.bcast_vld && !done_ff[2];
   assign sel_x = rem_x;
   assign sel_c = !rem_x && rem_c;
   assign is_last = sel_x ? !(rem_c || rem_b) : (sel_c ? !rem_b : 1'b1);

   assign bprod  = 28'(head_job.bcast_y) * 28'(mcg_pkg::BCAST_RECIP);
   assign bquot  = bprod[mcg_pkg::BCAST_RECIP_SHIFT +: 8];
   assign bvalue = (bquot > mcg_pkg::BCAST_MAX) ? 7'(mcg_pkg::BCAST_MAX) : bquot[6:0];

   assign load = queue_nonempty && (!valid_ff || !rsp_stall);
   assign pop  = load && is_last;

   always_comb begin
      done_in    = done_ff;
      valid_in   = valid_ff;
      kind_in    = kind_ff;
      status_in  = status_ff;
      channel_in = channel_ff;
      ctrl_in    = ctrl_ff;
      value_in   = value_ff;
      last_in    = last_ff;
      if (load) begin
         valid_in = 1'b1;
         last_in  = is_last;
         done_in  = is_last ? 3'b000 : (done_ff | {1'b0, sel_c, sel_x});
         if (sel_x || sel_c) begin
            kind_in    = mcg_pkg::MSG_REALTIME;
            status_in  = sel_c ? mcg_pkg::ST_CLOCK :
                         (head_job.xport_start ? mcg_pkg::ST_START : mcg_pkg::ST_STOP);
            channel_in = '0;
            ctrl_in    = '0;
            value_in   = '0;
         end else begin
            kind_in    = mcg_pkg::MSG_CONTROL;
            status_in  = {mcg_pkg::CC_STATUS_HI, cfg.channel};
            channel_in = cfg.channel;
            ctrl_in    = cfg.broadcast;
            value_in   = bvalue;
         end
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      status_ff  <= status_in;
      channel_ff <= channel_in;
      ctrl_ff    <= ctrl_in;
      value_ff   <= value_in;
      last_ff    <= last_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_msg_kind       = kind_ff;
   assign rsp_status_byte    = status_ff;
   assign rsp_out_channel    = channel_ff;
   assign rsp_out_controller = ctrl_ff;
   assign rsp_out_value      = value_ff;
   assign rsp_last           = last_ff;

   a_done_clear_on_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> done_ff == 3'b000)
      else $error("job progress not cleared after pop");

endmodule

>>> sv/midi_clock_generator.sv
`timescale 1ns / 1ps
// MIDI beat clock generator top level: configuration registers, front, job queue, back.
// Depends on mcg_pkg, mcg_front, mcg_queue, mcg_back.
//
//   channel | direction | handshake          | word
//   req_    | in        | req_valid/stall    | tick or controller message
//   rsp_    | out       | rsp_valid/stall    | realtime byte or controller change
//   csr_    | in        | csr_write          | register index and data
//
// An item is taken every cycle while the four-entry job queue has room; ticks that
// do not wrap, wraps with nothing to send and controller messages leave no job. Any
// other wrap queues one job of one to three words, which the back emits one word per
// cycle, unless the output is stalled, through its output register.
// Reset is synchronous and restores the register defaults; a stalled output holds its
// word while the front keeps taking items as long as the queue has room.
module midi_clock_generator #(
   parameter int PULSES_PER_BEAT = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [3:0]  req_in_channel,
   input  logic [6:0]  req_in_controller,
   input  logic [6:0]  req_in_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_msg_kind,
   output logic [7:0]  rsp_status_byte,
   output logic [3:0]  rsp_out_channel,
   output logic [6:0]  rsp_out_controller,
   output logic [6:0]  rsp_out_value,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   mcg_pkg::cfg_type cfg_ff, cfg_in;
   logic             tempo_load;
   logic             queue_full;
   logic             queue_nonempty;
   logic             push;
   logic             pop;
   mcg_pkg::job_type push_job;
   mcg_pkg::job_type head_job;

   always_comb begin
      cfg_in     = cfg_ff;
      tempo_load = 1'b0;
      if (csr_write) begin
         unique case (mcg_pkg::csr_index_type'(csr_index))
            mcg_pkg::CSR_INITIAL_TEMPO:        tempo_load = 1'b1;
            mcg_pkg::CSR_PHASE_LIMIT:
               cfg_in.limit = (csr_data == '0) ? 32'd1 : csr_data;
            mcg_pkg::CSR_CONTROL_CHANNEL:      cfg_in.channel   = csr_data[3:0];
            mcg_pkg::CSR_STEER_CONTROLLER:     cfg_in.steer     = csr_data[6:0];
            mcg_pkg::CSR_TRANSPORT_CONTROLLER: cfg_in.transport = csr_data[6:0];
            mcg_pkg::CSR_BROADCAST_CONTROLLER: cfg_in.broadcast = csr_data[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.limit     <= mcg_pkg::RESET_LIMIT;
         cfg_ff.channel   <= mcg_pkg::RESET_CHANNEL;
         cfg_ff.steer     <= mcg_pkg::RESET_STEER;
         cfg_ff.transport <= mcg_pkg::RESET_TRANSPORT;
         cfg_ff.broadcast <= mcg_pkg::RESET_BROADCAST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mcg_front #(
      .PULSES_PER_BEAT(PULSES_PER_BEAT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_in_channel   (req_in_channel),
      .req_in_controller(req_in_controller),
      .req_in_value     (req_in_value),
      .cfg              (cfg_ff),
      .tempo_load       (tempo_load),
      .tempo_load_value (csr_data[16:0]),
      .queue_full       (queue_full),
      .push             (push),
      .push_job         (push_job)
   );

   mcg_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_job(push_job),
      .pop     (pop),
      .head_job(head_job),
      .nonempty(queue_nonempty),
      .full    (queue_full)
   );

   mcg_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .head_job          (head_job),
      .queue_nonempty    (queue_nonempty),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_msg_kind      (rsp_msg_kind),
      .rsp_status_byte   (rsp_status_byte),
      .rsp_out_channel   (rsp_out_channel),
      .rsp_out_controller(rsp_out_controller),
      .rsp_out_value     (rsp_out_value),
      .rsp_last          (rsp_last)
   );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for midi_clock_generator: sends ticks and controller words,
// predicts every realtime and tempo broadcast word and compares them field by field.
// Depends on mcg_pkg and the midi_clock_generator RTL.
module testbench;

   localparam int     PULSES        = 24;
   localparam int     MAX_GAP       = 11;
   localparam int     SETTLE_CYCLES = 20;
   localparam int     CYCLE_LIMIT   = 300000;
   localparam int     RANDOM_ITEMS  = 52;
   localparam int     PHASE_ITEMS   = 26;
   localparam int     REPORT_LIMIT  = 10;
   localparam logic [1:0] XPORT_UNKNOWN = 2'd2;

   typedef struct {
      logic       kind;
      logic [7:0] status;
      logic [3:0] channel;
      logic [6:0] controller;
      logic [6:0] value;
      logic       last;
   } midi_word_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_cmd;
   logic [3:0]  req_in_channel;
   logic [6:0]  req_in_controller;
   logic [6:0]  req_in_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_msg_kind;
   logic [7:0]  rsp_status_byte;
   logic [3:0]  rsp_out_channel;
   logic [6:0]  rsp_out_controller;
   logic [6:0]  rsp_out_value;
   logic        rsp_last;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   logic [31:0] cfg_phase_limit;
   logic [3:0]  cfg_channel;
   logic [6:0]  cfg_steer;
   logic [6:0]  cfg_transport;
   logic [6:0]  cfg_broadcast;

   logic [16:0] tempo_q8;
   logic [31:0] phase_acc;
   logic        playing;
   logic [1:0]  sent_transport;
   int          beat_count;

   midi_word_type expected_words[$];
   int          mismatches;
   int          words_checked;
   int          cycle_count;
   bit          req_idle;
   bit          rsp_idle;
   int          rsp_gap;
   int          rsp_hold;

   midi_clock_generator #(.PULSES_PER_BEAT(PULSES)) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_in_channel     (req_in_channel),
      .req_in_controller  (req_in_controller),
      .req_in_value       (req_in_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_msg_kind       (rsp_msg_kind),
      .rsp_status_byte    (rsp_status_byte),
      .rsp_out_channel    (rsp_out_channel),
      .rsp_out_controller (rsp_out_controller),
      .rsp_out_value      (rsp_out_value),
      .rsp_last           (rsp_last),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic midi_word_type make_word(input logic kind, input logic [7:0] status,
         input logic [3:0] ch, input logic [6:0] cc, input logic [6:0] val);
      midi_word_type w;
      w.kind = kind;
      w.status = status;
      w.channel = ch;
      w.controller = cc;
      w.value = val;
      w.last = 1'b0;
      return w;
   endfunction

   function automatic logic [6:0] broadcast_level(input logic [16:0] t);
      longint d;
      longint v;
      if (longint'(t) <= mcg_pkg::TEMPO_MIN_Q8) return 7'd0;
      d = longint'(t) - mcg_pkg::TEMPO_MIN_Q8;
      v = (d * 127 + mcg_pkg::TEMPO_SPAN_Q8 / 2) / mcg_pkg::TEMPO_SPAN_Q8;
      if (v > 127) v = 127;
      return v[6:0];
   endfunction

   function automatic void predict_clock_words(input logic cmd, input logic [3:0] ch,
         input logic [6:0] cc, input logic [6:0] val);
      longint lim;
      longint sum;
      longint nt;
      longint diff;
      int     first;
      if (cmd == mcg_pkg::CMD_CONTROL) begin
         if (ch != cfg_channel) return;
         if (cc == cfg_steer) begin
            nt = mcg_pkg::TEMPO_MIN_Q8 + (longint'(val) * mcg_pkg::TEMPO_SPAN_Q8 +
                 mcg_pkg::STEER_ROUND) / mcg_pkg::STEER_DIV;
            diff = (nt > longint'(tempo_q8)) ? nt - longint'(tempo_q8)
                                             : longint'(tempo_q8) - nt;
            if (diff > longint'(mcg_pkg::TEMPO_HYST_Q8)) tempo_q8 = nt[16:0];
         end else if (cc == cfg_transport) begin
            playing = (val >= 7'd64);
         end
         return;
      end
      lim = (cfg_phase_limit == 32'd0) ? 1 : longint'(cfg_phase_limit);
      sum = longint'(phase_acc) + longint'(tempo_q8);
      if (sum < lim) begin
         phase_acc = sum[31:0];
         return;
      end
      sum = sum - lim;
      if (sum >= lim) sum = lim - 1;
      phase_acc = sum[31:0];
      first = expected_words.size();
      if ({1'b0, playing} != sent_transport) begin
         expected_words.push_back(make_word(mcg_pkg::MSG_REALTIME,
                                            playing ? mcg_pkg::ST_START : mcg_pkg::ST_STOP,
                                            4'd0, 7'd0, 7'd0));
         sent_transport = {1'b0, playing};
      end
      if (playing) begin
         expected_words.push_back(make_word(mcg_pkg::MSG_REALTIME, mcg_pkg::ST_CLOCK,
                                            4'd0, 7'd0, 7'd0));
         beat_count++;
         if (beat_count >= PULSES) begin
            beat_count = 0;
            expected_words.push_back(make_word(mcg_pkg::MSG_CONTROL,
                                               {mcg_pkg::CC_STATUS_HI, cfg_channel},
                                               cfg_channel, cfg_broadcast,
                                               broadcast_level(tempo_q8)));
         end
      end
      if (expected_words.size() > first)
         expected_words[expected_words.size() - 1].last = 1'b1;
   endfunction

   function automatic string word_text(input midi_word_type w);
      return $sformatf("kind %0d status %02h ch %0d cc %0d val %0d last %0d",
                       w.kind, w.status, w.channel, w.controller, w.value, w.last);
   endfunction

   task automatic flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%s", what);
   endtask

   task automatic write_reg(input mcg_pkg::csr_index_type idx, input logic [31:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         mcg_pkg::CSR_INITIAL_TEMPO:        tempo_q8 = data[16:0];
         mcg_pkg::CSR_PHASE_LIMIT:          cfg_phase_limit = data;
         mcg_pkg::CSR_CONTROL_CHANNEL:      cfg_channel = data[3:0];
         mcg_pkg::CSR_STEER_CONTROLLER:     cfg_steer = data[6:0];
         mcg_pkg::CSR_TRANSPORT_CONTROLLER: cfg_transport = data[6:0];
         mcg_pkg::CSR_BROADCAST_CONTROLLER: cfg_broadcast = data[6:0];
         default: ;
      endcase
   endtask

   task automatic send_word(input logic cmd, input logic [3:0] ch, input logic [6:0] cc,
         input logic [6:0] val);
      int gap;
      gap = req_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_cmd           <= cmd;
      req_in_channel    <= ch;
      req_in_controller <= cc;
      req_in_value      <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_clock_words(cmd, ch, cc, val);
   endtask

   task automatic tick();
      send_word(mcg_pkg::CMD_TICK, 4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)),
                7'($urandom_range(0, 127)));
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic test_transport_and_beat();
      tick();
      tick();
      send_word(mcg_pkg::CMD_CONTROL, 4'd3, mcg_pkg::RESET_TRANSPORT, 7'd0);
      settle();
      write_reg(mcg_pkg::CSR_PHASE_LIMIT, 32'd1);
      tick();
      send_word(mcg_pkg::CMD_CONTROL, mcg_pkg::RESET_CHANNEL, mcg_pkg::RESET_TRANSPORT,
                7'd63);
      tick();
      tick();
      send_word(mcg_pkg::CMD_CONTROL, mcg_pkg::RESET_CHANNEL, mcg_pkg::RESET_TRANSPORT,
                7'd64);
      tick();
      send_word(mcg_pkg::CMD_CONTROL, mcg_pkg::RESET_CHANNEL, mcg_pkg::RESET_STEER, 7'd127);
      send_word(mcg_pkg::CMD_CONTROL, mcg_pkg::RESET_CHANNEL, mcg_pkg::RESET_STEER, 7'd0);
      send_word(mcg_pkg::CMD_CONTROL, mcg_pkg::RESET_CHANNEL, mcg_pkg::RESET_STEER, 7'd127);
      do tick(); while (beat_count != 0);
      settle();
   endtask

   task automatic test_register_extremes();
      write_reg(mcg_pkg::CSR_INITIAL_TEMPO, 32'd10304);
      write_reg(mcg_pkg::CSR_PHASE_LIMIT, 32'd0);
      write_reg(mcg_pkg::CSR_CONTROL_CHANNEL, 32'd0);
      write_reg(mcg_pkg::CSR_STEER_CONTROLLER, 32'd0);
      write_reg(mcg_pkg::CSR_TRANSPORT_CONTROLLER, 32'd0);
      write_reg(mcg_pkg::CSR_BROADCAST_CONTROLLER, 32'd0);
      send_word(mcg_pkg::CMD_CONTROL, 4'd0, 7'd0, 7'd0);
      tick();
      settle();
      write_reg(mcg_pkg::CSR_INITIAL_TEMPO, 32'd10305);
      send_word(mcg_pkg::CMD_CONTROL, 4'd0, 7'd0, 7'd0);
      tick();
      settle();
      write_reg(mcg_pkg::CSR_CONTROL_CHANNEL, 32'd15);
      write_reg(mcg_pkg::CSR_STEER_CONTROLLER, 32'd127);
      write_reg(mcg_pkg::CSR_TRANSPORT_CONTROLLER, 32'd126);
      write_reg(mcg_pkg::CSR_BROADCAST_CONTROLLER, 32'd127);
      send_word(mcg_pkg::CMD_CONTROL, 4'd15, 7'd126, 7'd0);
      tick();
      send_word(mcg_pkg::CMD_CONTROL, 4'd15, 7'd126, 7'd127);
      tick();
      settle();
      write_reg(mcg_pkg::CSR_PHASE_LIMIT, 32'hFFFF_FFFF);
      write_reg(mcg_pkg::CSR_INITIAL_TEMPO, 32'd131071);
      tick();
      tick();
      tick();
      settle();
      write_reg(mcg_pkg::CSR_PHASE_LIMIT, 32'd1000);
      tick();
      tick();
      settle();
      write_reg(mcg_pkg::CSR_INITIAL_TEMPO, 32'd0);
      write_reg(mcg_pkg::CSR_PHASE_LIMIT, 32'd1);
      tick();
      tick();
      settle();
   endtask

   task automatic test_backpressure();
      write_reg(mcg_pkg::CSR_INITIAL_TEMPO, 32'd102400);
      write_reg(mcg_pkg::CSR_PHASE_LIMIT, 32'd1);
      send_word(mcg_pkg::CMD_CONTROL, cfg_channel, cfg_transport, 7'd127);
      req_idle = 1'b0;
      rsp_hold = 200;
      repeat (PULSES) tick();
      settle();
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      repeat (8) tick();
      settle();
   endtask

   task automatic test_random_traffic();
      int          sent;
      int          pick;
      int          i;
      logic [31:0] t;
      logic [31:0] lim;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         settle();
         case ($urandom_range(0, 4))
            0:       t = mcg_pkg::TEMPO_MIN_Q8;
            1:       t = mcg_pkg::TEMPO_MIN_Q8 + mcg_pkg::TEMPO_SPAN_Q8;
            2:       t = 32'd131071;
            default: t = $urandom_range(0, 131071);
         endcase
         case ($urandom_range(0, 5))
            0:       lim = 32'd0;
            1:       lim = 32'd1;
            default: lim = $urandom_range(1, 4 * t + 4);
         endcase
         write_reg(mcg_pkg::CSR_INITIAL_TEMPO, t);
         write_reg(mcg_pkg::CSR_PHASE_LIMIT, lim);
         write_reg(mcg_pkg::CSR_CONTROL_CHANNEL, $urandom_range(0, 15));
         write_reg(mcg_pkg::CSR_STEER_CONTROLLER, $urandom_range(0, 127));
         if ($urandom_range(0, 7) == 0)
            write_reg(mcg_pkg::CSR_TRANSPORT_CONTROLLER, {25'd0, cfg_steer});
         else
            write_reg(mcg_pkg::CSR_TRANSPORT_CONTROLLER, $urandom_range(0, 127));
         write_reg(mcg_pkg::CSR_BROADCAST_CONTROLLER, $urandom_range(0, 127));
         req_idle = ($urandom_range(0, 3) != 0);
         rsp_idle = ($urandom_range(0, 3) != 0);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            pick = $urandom_range(0, 19);
            sent++;
            if (pick < 13) begin
               tick();
            end else if (pick < 15) begin
               send_word(mcg_pkg::CMD_CONTROL, cfg_channel, cfg_steer,
                         7'($urandom_range(0, 127)));
            end else if (pick < 17) begin
               send_word(mcg_pkg::CMD_CONTROL, cfg_channel, cfg_transport,
                         7'($urandom_range(0, 127)));
            end else begin
               send_word(mcg_pkg::CMD_CONTROL, 4'($urandom_range(0, 15)),
                         7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
            end
         end
      end
      settle();
   endtask

   initial begin : stall_driver
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold--;
         end else if (rsp_gap > 0) begin
            rsp_stall <= 1'b1;
            rsp_gap--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : response_check
      midi_word_type got;
      midi_word_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.kind       = rsp_msg_kind;
            got.status     = rsp_status_byte;
            got.channel    = rsp_out_channel;
            got.controller = rsp_out_controller;
            got.value      = rsp_out_value;
            got.last       = rsp_last;
            rsp_gap = rsp_idle ? $urandom_range(0, MAX_GAP) : 0;
            words_checked++;
            if (expected_words.size() == 0) begin
               flag_mismatch({"unexpected word: ", word_text(got)});
            end else begin
               want = expected_words.pop_front();
               if (got.kind !== want.kind || got.status !== want.status ||
                   got.channel !== want.channel || got.controller !== want.controller ||
                   got.value !== want.value || got.last !== want.last)
                  flag_mismatch({"expected ", word_text(want), " got ", word_text(got)});
            end
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : run
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = mcg_pkg::CMD_TICK;
      req_in_channel = 4'd0;
      req_in_controller = 7'd0;
      req_in_value = 7'd0;
      csr_write = 1'b0;
      csr_index = mcg_pkg::CSR_INITIAL_TEMPO;
      csr_data = 32'd0;
      mismatches = 0;
      words_checked = 0;
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      rsp_gap = 0;
      rsp_hold = 0;
      cfg_phase_limit = mcg_pkg::RESET_LIMIT;
      cfg_channel = mcg_pkg::RESET_CHANNEL;
      cfg_steer = mcg_pkg::RESET_STEER;
      cfg_transport = mcg_pkg::RESET_TRANSPORT;
      cfg_broadcast = mcg_pkg::RESET_BROADCAST;
      tempo_q8 = mcg_pkg::RESET_TEMPO;
      phase_acc = 32'd0;
      playing = 1'b1;
      sent_transport = XPORT_UNKNOWN;
      beat_count = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_transport_and_beat();
      test_register_extremes();
      test_backpressure();
      test_random_traffic();
      if (mismatches == 0 && expected_words.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
